>>> rtl/core/bsed_pkg.sv
package bsed_pkg;

  // Default sizes of the history ring and the band range.
  localparam int MAX_WINDOW_DEF = 64;
  localparam int MAX_BANDS_DEF  = 64;

  // Fixed field widths.
  localparam int WIN_W    = 7;
  localparam int SUM_W    = 38;
  localparam int ENERGY_W = 32;
  localparam int CUT_W    = 6;
  localparam int IDX_W    = 2;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LOW_THR  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HIGH_THR = 2'd2;

  // Register values after reset.
  localparam logic [WIN_W-1:0] WINDOW_RST   = 7'd50;
  localparam logic [SUM_W-1:0] LOW_THR_RST  = 38'd167772;
  localparam logic [SUM_W-1:0] HIGH_THR_RST = 38'd1678;

  // Depth of the result queue.
  localparam int OBUF_DEPTH = 4;

  // Control flags that travel with one band update through the pipeline.
  typedef struct packed {
    logic vld;        // an update is present
    logic is_band;    // a received band (clear for zero-fill updates)
    logic frame_end;  // the received band closes the frame
    logic emit;       // the frame end produces a result
    logic sub;        // the window is full, so the oldest energy is removed
  } bsed_op_t;

endpackage

>>> rtl/core/bsed_ctrl.sv
module bsed_ctrl #(
  parameter int MAX_WINDOW = bsed_pkg::MAX_WINDOW_DEF,
  parameter int MAX_BANDS  = bsed_pkg::MAX_BANDS_DEF,
  parameter int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  parameter int HAW = (MAX_WINDOW * MAX_BANDS > 1) ? $clog2(MAX_WINDOW * MAX_BANDS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_i,
  input  logic [bsed_pkg::WIN_W-1:0]     window_i,
  input  logic                           room_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bsed_pkg::ENERGY_W-1:0]  in_energy_i,
  input  logic                           in_last_i,
  output bsed_pkg::bsed_op_t             op_o,
  output logic [BW-1:0]                  op_band_o,
  output logic [bsed_pkg::ENERGY_W-1:0]  op_energy_o,
  output logic [HAW-1:0]                 op_rd_addr_o,
  output logic [HAW-1:0]                 op_wr_addr_o
);

  localparam int SLW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WSW = $clog2(MAX_WINDOW + 1);

  logic [BW-1:0]  band_r;
  logic [SLW-1:0] slot_r;
  logic [WSW-1:0] seen_r;
  logic           fill_r;
  logic [BW-1:0]  fill_band_r;

  logic [WSW-1:0] win;
  logic [WSW:0]   slot_ext;
  logic [WSW:0]   win_ext;
  logic [SLW-1:0] old_slot;
  logic [WSW-1:0] seen_nxt;
  logic [SLW-1:0] slot_nxt;
  logic [BW-1:0]  cur_band;
  logic           accept;
  logic           band_top;
  logic           frame_end;
  logic           advance;

  // Effective window: zero acts as one, large values clamp to the ring size.
  always_comb begin
    if (window_i == '0) begin
      win = WSW'(1);
    end else if (int'(window_i) > MAX_WINDOW) begin
      win = WSW'(MAX_WINDOW);
    end else begin
      win = WSW'(window_i);
    end
  end

  // Ring slot of the frame that leaves the window.
  always_comb begin
    slot_ext = (WSW+1)'(slot_r);
    win_ext  = (WSW+1)'(win);
    if (slot_ext >= win_ext) begin
      old_slot = SLW'(slot_ext - win_ext);
    end else begin
      old_slot = SLW'(slot_ext + (WSW+1)'(MAX_WINDOW) - win_ext);
    end
  end

  // Frame counters as they stand after the current frame closes.
  assign seen_nxt = (seen_r == WSW'(MAX_WINDOW)) ? seen_r : seen_r + 1'b1;
  assign slot_nxt = (slot_r == SLW'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;

  // Input handshake: zero-fill and a full result queue hold off new bands.
  assign in_ready_o = !fill_r && room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign band_top   = (band_r == BW'(MAX_BANDS - 1));
  assign frame_end  = in_last_i || band_top;
  assign advance    = (accept && band_top) ||
                      (fill_r && fill_band_r == BW'(MAX_BANDS - 1));

  // Update issue: a fill band or a received band.
  always_comb begin
    op_o = '0;
    cur_band    = fill_r ? fill_band_r : band_r;
    op_band_o   = cur_band;
    op_energy_o = fill_r ? '0 : in_energy_i;
    op_o.vld       = fill_r || accept;
    op_o.is_band   = !fill_r;
    op_o.frame_end = !fill_r && frame_end;
    op_o.emit      = !fill_r && frame_end && (seen_nxt >= win);
    op_o.sub       = (seen_r >= win);
    op_rd_addr_o = HAW'(HAW'(old_slot) * HAW'(MAX_BANDS) + HAW'(cur_band));
    op_wr_addr_o = HAW'(HAW'(slot_r) * HAW'(MAX_BANDS) + HAW'(cur_band));
  end

  // Band position, zero-fill sequencer and frame counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r      <= '0;
      slot_r      <= '0;
      seen_r      <= '0;
      fill_r      <= 1'b0;
      fill_band_r <= '0;
    end else if (clr_i) begin
      band_r <= '0;
      seen_r <= '0;
      fill_r <= 1'b0;
    end else begin
      if (accept) begin
        if (frame_end) begin
          band_r <= '0;
          if (!band_top) begin
            fill_r      <= 1'b1;
            fill_band_r <= band_r + 1'b1;
          end
        end else begin
          band_r <= band_r + 1'b1;
        end
      end
      if (fill_r) begin
        if (fill_band_r == BW'(MAX_BANDS - 1)) begin
          fill_r <= 1'b0;
        end else begin
          fill_band_r <= fill_band_r + 1'b1;
        end
      end
      if (advance) begin
        slot_r <= slot_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule

>>> rtl/core/bsed_sum.sv
module bsed_sum #(
  parameter int MAX_WINDOW = bsed_pkg::MAX_WINDOW_DEF,
  parameter int MAX_BANDS  = bsed_pkg::MAX_BANDS_DEF,
  parameter int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  parameter int HAW = (MAX_WINDOW * MAX_BANDS > 1) ? $clog2(MAX_WINDOW * MAX_BANDS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_i,
  input  bsed_pkg::bsed_op_t             op_i,
  input  logic [BW-1:0]                  op_band_i,
  input  logic [bsed_pkg::ENERGY_W-1:0]  op_energy_i,
  input  logic [HAW-1:0]                 op_rd_addr_i,
  input  logic [HAW-1:0]                 op_wr_addr_i,
  output bsed_pkg::bsed_op_t             s2_op_o,
  output logic [BW-1:0]                  s2_band_o,
  output logic [bsed_pkg::SUM_W-1:0]     s2_sum_o,
  output logic [1:0]                     pend_o
);

  localparam int SUM_W = bsed_pkg::SUM_W;
  localparam int E_W   = bsed_pkg::ENERGY_W;

  // Energy history ring and per-band window sums.
  logic [E_W-1:0]   hist_mem [MAX_WINDOW*MAX_BANDS];
  logic [SUM_W-1:0] sum_mem  [MAX_BANDS];
  logic [MAX_BANDS-1:0] sum_vld_r;

  logic [E_W-1:0]     hist_q_r;
  logic [SUM_W-1:0]   sum_q_r;
  bsed_pkg::bsed_op_t s1_op_r;
  logic [BW-1:0]      s1_band_r;
  logic [E_W-1:0]     s1_energy_r;
  logic [HAW-1:0]     s1_rd_addr_r;
  logic [HAW-1:0]     s1_wr_addr_r;

  logic               fw_vld_r;
  logic [BW-1:0]      fw_band_r;
  logic [SUM_W-1:0]   fw_sum_r;
  logic [HAW-1:0]     fw_addr_r;
  logic [E_W-1:0]     fw_energy_r;

  bsed_pkg::bsed_op_t s2_op_r;
  logic [BW-1:0]      s2_band_r;
  logic [SUM_W-1:0]   s2_sum_r;

  logic [SUM_W-1:0]   sum_old;
  logic [E_W-1:0]     hist_old;
  logic [SUM_W-1:0]   sum_nxt;

  // Registered memory reads, taken as an update enters the update stage.
  always_ff @(posedge clk) begin
    if (op_i.vld) begin
      hist_q_r <= hist_mem[op_rd_addr_i];
      sum_q_r  <= sum_mem[op_band_i];
    end
  end

  // Update stage control.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      s1_op_r <= '0;
    end else begin
      s1_op_r <= op_i;
    end
  end

  always_ff @(posedge clk) begin
    s1_band_r    <= op_band_i;
    s1_energy_r  <= op_energy_i;
    s1_rd_addr_r <= op_rd_addr_i;
    s1_wr_addr_r <= op_wr_addr_i;
  end

  // Bypass the write of the previous cycle, which the read did not see.
  always_comb begin
    if (!sum_vld_r[s1_band_r]) begin
      sum_old = '0;
    end else if (fw_vld_r && fw_band_r == s1_band_r) begin
      sum_old = fw_sum_r;
    end else begin
      sum_old = sum_q_r;
    end
    if (fw_vld_r && fw_addr_r == s1_rd_addr_r) begin
      hist_old = fw_energy_r;
    end else begin
      hist_old = hist_q_r;
    end
  end

  // Drop the oldest energy once the window is full, then add the new one.
  always_comb begin
    if (s1_op_r.sub) begin
      sum_nxt = sum_old - SUM_W'(hist_old) + SUM_W'(s1_energy_r);
    end else begin
      sum_nxt = sum_old + SUM_W'(s1_energy_r);
    end
  end

  // Write back both memories.
  always_ff @(posedge clk) begin
    if (s1_op_r.vld) begin
      sum_mem[s1_band_r]     <= sum_nxt;
      hist_mem[s1_wr_addr_r] <= s1_energy_r;
    end
  end

  // Sum valid bits: a band that was never written since a clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      sum_vld_r <= '0;
      fw_vld_r  <= 1'b0;
    end else begin
      if (s1_op_r.vld) begin
        sum_vld_r[s1_band_r] <= 1'b1;
      end
      fw_vld_r <= s1_op_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    fw_band_r   <= s1_band_r;
    fw_sum_r    <= sum_nxt;
    fw_addr_r   <= s1_wr_addr_r;
    fw_energy_r <= s1_energy_r;
  end

  // Result stage toward the run trackers.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      s2_op_r <= '0;
    end else begin
      s2_op_r <= s1_op_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_band_r <= s1_band_r;
    s2_sum_r  <= sum_nxt;
  end

  assign s2_op_o   = s2_op_r;
  assign s2_band_o = s2_band_r;
  assign s2_sum_o  = s2_sum_r;
  assign pend_o    = 2'(s1_op_r.vld && s1_op_r.emit) + 2'(s2_op_r.vld && s2_op_r.emit);

endmodule

>>> rtl/core/bsed_track.sv
module bsed_track #(
  parameter int MAX_BANDS = bsed_pkg::MAX_BANDS_DEF,
  parameter int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr_i,
  input  logic [bsed_pkg::SUM_W-1:0]   low_thr_i,
  input  logic [bsed_pkg::SUM_W-1:0]   high_thr_i,
  input  bsed_pkg::bsed_op_t           op_i,
  input  logic [BW-1:0]                band_i,
  input  logic [bsed_pkg::SUM_W-1:0]   sum_i,
  output logic                         push_o,
  output logic [bsed_pkg::CUT_W-1:0]   low_o,
  output logic [bsed_pkg::CUT_W-1:0]   high_o
);

  localparam int CUT_W = bsed_pkg::CUT_W;
  localparam int XW    = CUT_W + BW + 1;

  logic          open_r;
  logic [BW-1:0] lead_r;
  logic [BW:0]   trail_r;

  logic          open_nxt;
  logic [BW-1:0] lead_nxt;
  logic [BW:0]   trail_nxt;
  logic [XW-1:0] low_ext;
  logic [XW-1:0] high_ext;
  logic          upd;

  assign upd = op_i.vld && op_i.is_band;

  // Leading and trailing quiet runs of the current frame.
  always_comb begin
    open_nxt  = open_r && (sum_i < low_thr_i);
    lead_nxt  = open_nxt ? band_i : lead_r;
    trail_nxt = (sum_i < high_thr_i) ? trail_r + 1'b1 : '0;
    low_ext   = XW'(lead_nxt);
    high_ext  = (trail_nxt == '0) ? '0 : XW'(trail_nxt - 1'b1);
  end

  assign push_o = upd && op_i.emit;
  assign low_o  = low_ext[CUT_W-1:0];
  assign high_o = high_ext[CUT_W-1:0];

  // Trackers restart at each frame end.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      open_r  <= 1'b1;
      lead_r  <= '0;
      trail_r <= '0;
    end else if (upd) begin
      if (op_i.frame_end) begin
        open_r  <= 1'b1;
        lead_r  <= '0;
        trail_r <= '0;
      end else begin
        open_r  <= open_nxt;
        lead_r  <= lead_nxt;
        trail_r <= trail_nxt;
      end
    end
  end

endmodule

>>> rtl/core/bsed_obuf.sv
module bsed_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  logic [2*bsed_pkg::CUT_W-1:0]  data_i,
  input  logic [1:0]                    pend_i,
  output logic                          room_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2*bsed_pkg::CUT_W-1:0]  out_data_o
);

  localparam int DEPTH = bsed_pkg::OBUF_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [2*bsed_pkg::CUT_W-1:0] buf_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          pop;
  logic [CW:0]   committed;

  assign out_valid_o = (cnt_r != '0);
  assign out_data_o  = buf_r[rd_ptr_r];
  assign pop         = out_valid_o && out_ready_i;

  // A new request is taken only if every result in flight still has a slot.
  assign committed = (CW+1)'(cnt_r) + (CW+1)'(pend_i);
  assign room_o    = (committed <= (CW+1)'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push_i) begin
      buf_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push_i) - CW'(pop);
    end
  end

endmodule

>>> rtl/core/band_silence_edge_detector.sv
// Band silence edge detector.
// The input stream carries one band energy per request (unsigned Q8.24 in
// in_tdata), in band order, with in_tlast on the final band of each frame.
// Each band keeps a sliding sum over the last window_frames frames. Once the
// window holds enough frames, every frame end yields one result on the output
// stream with the low and high cutoffs.
// Bands flow at one per cycle while the result queue has room. A frame that
// ends before band MAX_BANDS-1 is padded with zero energy for the remaining
// bands, one per cycle, and in_tready stays low during that padding.
// A result is registered in the update and result stages, then in the queue.
// Results wait in a four-entry queue; when the receiver stalls, new bands are
// still taken as long as every pending result has a queue slot.
// Reset (rst_n low at a clock edge) restores the register defaults, clears the
// band sums and the frame count; no clearing pass runs. Writing window_frames
// restarts filling in the same way; threshold writes apply at once.
module band_silence_edge_detector #(
  parameter int MAX_WINDOW = bsed_pkg::MAX_WINDOW_DEF,
  parameter int MAX_BANDS  = bsed_pkg::MAX_BANDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [31:0] band_energy
  input  logic                         in_tlast,   // last_band
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [5:0] low_cutoff, [11:6] high_cutoff
  input  logic                         cfg_wr_en,
  input  logic [bsed_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [bsed_pkg::SUM_W-1:0]   cfg_wdata
);

  localparam int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int HAW = (MAX_WINDOW * MAX_BANDS > 1) ? $clog2(MAX_WINDOW * MAX_BANDS) : 1;
  localparam int CUT_W = bsed_pkg::CUT_W;

  logic [bsed_pkg::WIN_W-1:0] window_r;
  logic [bsed_pkg::SUM_W-1:0] low_thr_r;
  logic [bsed_pkg::SUM_W-1:0] high_thr_r;
  logic                       clr;

  bsed_pkg::bsed_op_t          op;
  logic [BW-1:0]               op_band;
  logic [bsed_pkg::ENERGY_W-1:0] op_energy;
  logic [HAW-1:0]              op_rd_addr;
  logic [HAW-1:0]              op_wr_addr;
  bsed_pkg::bsed_op_t          s2_op;
  logic [BW-1:0]               s2_band;
  logic [bsed_pkg::SUM_W-1:0]  s2_sum;
  logic [1:0]                  pend;
  logic                        room;
  logic                        push;
  logic [CUT_W-1:0]            low_cut;
  logic [CUT_W-1:0]            high_cut;
  logic [2*CUT_W-1:0]          res_data;
  logic [2*CUT_W-1:0]          out_res;

  // Window rewrite restarts the sums.
  assign clr = cfg_wr_en && (cfg_idx == bsed_pkg::REG_WINDOW);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= bsed_pkg::WINDOW_RST;
      low_thr_r  <= bsed_pkg::LOW_THR_RST;
      high_thr_r <= bsed_pkg::HIGH_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        bsed_pkg::REG_WINDOW:   window_r   <= cfg_wdata[bsed_pkg::WIN_W-1:0];
        bsed_pkg::REG_LOW_THR:  low_thr_r  <= cfg_wdata;
        bsed_pkg::REG_HIGH_THR: high_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bsed_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_BANDS  (MAX_BANDS),
    .BW         (BW),
    .HAW        (HAW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .clr_i        (clr),
    .window_i     (window_r),
    .room_i       (room),
    .in_valid_i   (in_tvalid),
    .in_ready_o   (in_tready),
    .in_energy_i  (in_tdata),
    .in_last_i    (in_tlast),
    .op_o         (op),
    .op_band_o    (op_band),
    .op_energy_o  (op_energy),
    .op_rd_addr_o (op_rd_addr),
    .op_wr_addr_o (op_wr_addr)
  );

  bsed_sum #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_BANDS  (MAX_BANDS),
    .BW         (BW),
    .HAW        (HAW)
  ) u_sum (
    .clk          (clk),
    .rst_n        (rst_n),
    .clr_i        (clr),
    .op_i         (op),
    .op_band_i    (op_band),
    .op_energy_i  (op_energy),
    .op_rd_addr_i (op_rd_addr),
    .op_wr_addr_i (op_wr_addr),
    .s2_op_o      (s2_op),
    .s2_band_o    (s2_band),
    .s2_sum_o     (s2_sum),
    .pend_o       (pend)
  );

  bsed_track #(
    .MAX_BANDS (MAX_BANDS),
    .BW        (BW)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_i      (clr),
    .low_thr_i  (low_thr_r),
    .high_thr_i (high_thr_r),
    .op_i       (s2_op),
    .band_i     (s2_band),
    .sum_i      (s2_sum),
    .push_o     (push),
    .low_o      (low_cut),
    .high_o     (high_cut)
  );

  assign res_data = {high_cut, low_cut};

  bsed_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .data_i      (res_data),
    .pend_i      (pend),
    .room_o      (room),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_res)
  );

  // Cutoffs in the low bits, zero padding above.
  assign out_tdata = 16'(out_res);

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import bsed_pkg::*;

  localparam int NBANDS = MAX_BANDS_DEF;
  localparam int NSLOTS = MAX_WINDOW_DEF;
  localparam int ITEM_TARGET = 1500;
  localparam int QUIET_TAIL = 200;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [CUT_W-1:0] low;
    logic [CUT_W-1:0] high;
  } cutoff_t;

  typedef enum logic {ROW_WRITE, ROW_BAND} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [IDX_W-1:0]    idx;
    logic [SUM_W-1:0]    value;
    logic [ENERGY_W-1:0] energy;
    logic                last;
    logic                fixed;
    logic [CUT_W-1:0]    low;
    logic [CUT_W-1:0]    high;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [SUM_W-1:0] cfg_wdata = '0;

  band_silence_edge_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shared run state.
  cutoff_t pending_cutoffs [$];
  int mismatch_count = 0;
  int bands_sent = 0;
  int hold_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int cycle_count = 0;

  // Shadow copy of the block: registers, band sums, history ring and run trackers.
  logic [ENERGY_W-1:0] energy_ring [NSLOTS][NBANDS];
  logic [SUM_W-1:0]    win_sum [NBANDS];
  logic [WIN_W-1:0]    window_reg;
  logic [SUM_W-1:0]    low_thr;
  logic [SUM_W-1:0]    high_thr;
  logic [6:0]          frames_filled;
  logic [5:0]          ring_slot;
  logic [5:0]          band_idx;
  logic [5:0]          lead_cut;
  logic                lead_open;
  logic [6:0]          trail_len;

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int window_span();
    if (window_reg == '0) return 1;
    if (int'(window_reg) > NSLOTS) return NSLOTS;
    return int'(window_reg);
  endfunction

  function automatic void restart_frame();
    band_idx = '0;
    lead_open = 1'b1;
    lead_cut = '0;
    trail_len = '0;
  endfunction

  function automatic void restart_window();
    foreach (win_sum[b]) win_sum[b] = '0;
    frames_filled = '0;
    restart_frame();
  endfunction

  // Slide one band's window sum: drop the oldest frame once full, add the new energy.
  function automatic void accumulate_band(int b, logic [ENERGY_W-1:0] e, int w);
    logic [5:0] old_slot;
    old_slot = ring_slot - 6'(w);
    if (int'(frames_filled) >= w) win_sum[b] = win_sum[b] - SUM_W'(energy_ring[old_slot][b]);
    win_sum[b] = win_sum[b] + SUM_W'(e);
    energy_ring[ring_slot][b] = e;
  endfunction

  // Advance the shadow copy by one band; queue the cutoffs when a frame yields them.
  function automatic bit track_band(logic [ENERGY_W-1:0] e, logic last);
    int w;
    int b;
    logic [SUM_W-1:0] s;
    cutoff_t res;
    w = window_span();
    b = int'(band_idx);
    accumulate_band(b, e, w);
    s = win_sum[b];
    if (lead_open && s < low_thr) lead_cut = band_idx;
    else lead_open = 1'b0;
    if (s < high_thr) trail_len = trail_len + 7'd1;
    else trail_len = '0;
    if (!last && b + 1 < NBANDS) begin
      band_idx = band_idx + 6'd1;
      return 1'b0;
    end
    // Bands past the frame end count as zero energy.
    for (int k = b + 1; k < NBANDS; k++) accumulate_band(k, '0, w);
    res.low = lead_cut;
    res.high = (trail_len != 0) ? CUT_W'(trail_len - 7'd1) : '0;
    ring_slot = ring_slot + 6'd1;
    if (int'(frames_filled) < NSLOTS) frames_filled = frames_filled + 7'd1;
    restart_frame();
    if (int'(frames_filled) < w) return 1'b0;
    pending_cutoffs.insert(pending_cutoffs.size(), res);
    return 1'b1;
  endfunction

  // Offer one band, optionally after an idle burst, and wait for the request to be taken.
  task automatic push_band(logic [ENERGY_W-1:0] e, logic last, output bit made);
    if (bands_sent >= ITEM_TARGET - QUIET_TAIL) begin
      tx_idle = 1'b0;
      rx_idle = 1'b0;
    end
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= e;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    made = track_band(e, last);
    bands_sent++;
  endtask

  // Stop offering and wait until every expected result is out and the padding is done.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_cutoffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SUM_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      REG_WINDOW: begin
        window_reg = value[WIN_W-1:0];
        restart_window();
      end
      REG_LOW_THR: low_thr = value;
      REG_HIGH_THR: high_thr = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Opening sequence: default thresholds at their boundary, threshold extremes,
  // window of zero, ignored register, partial window and a window rewrite mid-frame.
  plan_row_t opening_plan [32] = '{
    '{ROW_WRITE, REG_WINDOW,   38'd1,   32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd0,         1'b1, 1'b1, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd167771,    1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd1677,      1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd1678,      1'b1, 1'b1, 6'd2, 6'd0},
    '{ROW_WRITE, REG_LOW_THR,  SUM_MAX, 32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_HIGH_THR, 38'd0,   32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd5,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 6'd2, 6'd0},
    '{ROW_WRITE, REG_LOW_THR,  38'd0,   32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_HIGH_THR, SUM_MAX, 32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd1,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd2,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd3,         1'b1, 1'b1, 6'd0, 6'd2},
    '{ROW_WRITE, REG_WINDOW,   38'd0,   32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_LOW_THR,  38'd100, 32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_HIGH_THR, 38'd100, 32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd50,        1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd200,       1'b1, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd200,       1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd50,        1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd50,        1'b1, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_UNUSED,   38'h2A,  32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd99,        1'b1, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_WINDOW,   38'd2,   32'd0,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd40,        1'b1, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd40,        1'b1, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd7,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd8,         1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_WRITE, REG_WINDOW,   38'h3F_FFFF_FF81, 32'd0, 1'b0, 1'b0, 6'd0, 6'd0},
    '{ROW_BAND,  REG_WINDOW,   38'd0,   32'd9,         1'b1, 1'b0, 6'd0, 6'd0}
  };

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check each taken result, then decide the next ready level.
  initial begin
    int stall_left;
    cutoff_t got;
    cutoff_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.low = out_tdata[CUT_W-1:0];
        got.high = out_tdata[2*CUT_W-1:CUT_W];
        if (pending_cutoffs.size() == 0) begin
          flag_mismatch($sformatf("result low=%0d high=%0d with none expected",
                                  got.low, got.high));
        end else begin
          want = pending_cutoffs.pop_front();
          if (got.low !== want.low)
            flag_mismatch($sformatf("low_cutoff %0d, expected %0d", got.low, want.low));
          if (got.high !== want.high)
            flag_mismatch($sformatf("high_cutoff %0d, expected %0d", got.high, want.high));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: opening sequence, then random phases of settings and frames.
  initial begin
    plan_row_t row;
    bit made;
    int phase;
    int win;
    int w_eff;
    int nframes;
    int band_hi;
    int lead_q;
    int trail_q;
    int n;
    bit overrun;
    bit chaotic;
    bit quiet;
    logic last;
    logic [ENERGY_W-1:0] e;
    logic [SUM_W-1:0] wval;
    logic [SUM_W-1:0] thr [2];

    window_reg = WINDOW_RST;
    low_thr = LOW_THR_RST;
    high_thr = HIGH_THR_RST;
    ring_slot = '0;
    restart_window();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_plan[r]) begin
      row = opening_plan[r];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.value);
      end else begin
        push_band(row.energy, row.last, made);
        if (row.fixed) begin
          if (!made) flag_mismatch($sformatf("opening row %0d gives no result", r));
          else pending_cutoffs[$] = '{low: row.low, high: row.high};
        end
      end
    end

    phase = 0;
    while (bands_sent < ITEM_TARGET) begin
      // Pick a window; the first phases cover the large extremes and the stall test.
      case (phase)
        0: win = 127;
        1: win = 64;
        2: win = 1;
        default: begin
          case ($urandom_range(0, 19)) inside
            0: win = 0;
            1: win = 64;
            2: win = 127;
            [3:5]: win = $urandom_range(5, 16);
            default: win = $urandom_range(1, 4);
          endcase
        end
      endcase
      w_eff = (win == 0) ? 1 : ((win > NSLOTS) ? NSLOTS : win);

      for (int j = 0; j < 2; j++) begin
        case ($urandom_range(0, 9))
          0: thr[j] = '0;
          1: thr[j] = SUM_MAX;
          2: thr[j] = {6'($urandom), 32'($urandom)};
          default: thr[j] = SUM_W'(w_eff * $urandom_range(100, 1500));
        endcase
      end

      drain_results();
      wval = SUM_W'(win);
      if ($urandom_range(0, 3) == 0) wval[SUM_W-1:WIN_W] = 31'($urandom);
      write_reg(REG_WINDOW, wval);
      write_reg(REG_LOW_THR, thr[0]);
      write_reg(REG_HIGH_THR, thr[1]);
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, {6'($urandom), 32'($urandom)});

      if (w_eff >= 16) band_hi = 2;
      else if ($urandom_range(0, 9) == 0) band_hi = NBANDS;
      else band_hi = 8;
      nframes = w_eff + $urandom_range(3, 12);
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);

      // Stall test: the receiver holds off while single-band frames keep coming.
      if (phase == 2) begin
        band_hi = 1;
        nframes = 30;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_cycles = 400;
      end

      lead_q = $urandom_range(0, band_hi);
      trail_q = $urandom_range(0, band_hi);
      for (int f = 0; f < nframes && bands_sent < ITEM_TARGET; f++) begin
        chaotic = ($urandom_range(0, 19) == 0);
        overrun = (phase != 2) && ($urandom_range(0, 14) == 0);
        n = overrun ? NBANDS + $urandom_range(0, 6) : $urandom_range(1, band_hi);
        for (int i = 0; i < n; i++) begin
          quiet = (i < lead_q) || (i >= n - trail_q);
          if ($urandom_range(0, 9) == 0) quiet = !quiet;
          if (quiet) e = $urandom_range(0, 300);
          else if ($urandom_range(0, 5) == 0) e = $urandom;
          else e = $urandom_range(1500, 200000);
          if (chaotic) last = ($urandom_range(0, 2) == 0);
          else last = !overrun && (i == n - 1);
          push_band(e, last, made);
        end
      end
      phase++;
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> band_silence_edge_detector.f
rtl/core/bsed_pkg.sv
rtl/core/bsed_ctrl.sv
rtl/core/bsed_sum.sv
rtl/core/bsed_track.sv
rtl/core/bsed_obuf.sv
rtl/core/band_silence_edge_detector.sv
verif/tb.sv
